### src/vcp_pkg.sv
// ----------------------------------------------------------------------------
// vcp_pkg
// Shared types, widths and constants of the vision centering PID loop.
// ----------------------------------------------------------------------------
package vcp_pkg;

    // Loop constants
    localparam int TICK_MS        = 20;
    localparam int GAIN_FRAC_BITS = 12;
    localparam int SUM_BITS       = 24;

    // Field widths
    localparam int COORD_W   = 10;
    localparam int ERR_W     = COORD_W + 1;
    localparam int DERR_W    = ERR_W + 1;
    localparam int GAIN_W    = 16;
    localparam int TIME_W    = 16;
    localparam int ELAPSED_W = 17;
    localparam int LIMIT_W   = 7;
    localparam int POWER_W   = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    // Product and sum widths: gains enter the multipliers as signed GAIN_W+1
    localparam int PROD_P_W = GAIN_W + 1 + ERR_W;
    localparam int PROD_I_W = GAIN_W + 1 + SUM_BITS;
    localparam int PROD_D_W = GAIN_W + 1 + DERR_W;
    localparam int TOTAL_W  = PROD_I_W + 2;

    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = {ELAPSED_W{1'b1}};

    // Register reset values
    localparam logic [COORD_W-1:0] TARGET_RST  = '0;
    localparam logic [TIME_W-1:0]  TIMEOUT_RST = '0;
    localparam logic [GAIN_W-1:0]  GAIN_P_RST  = GAIN_W'(819);
    localparam logic [GAIN_W-1:0]  GAIN_I_RST  = GAIN_W'(37);
    localparam logic [GAIN_W-1:0]  GAIN_D_RST  = GAIN_W'(1638);
    localparam logic [LIMIT_W-1:0] LIMIT_RST   = LIMIT_W'(67);
    localparam logic [COORD_W-1:0] GATE_RST    = COORD_W'(200);

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TARGET_X    = 3'd0,
        REG_TIMEOUT_MS  = 3'd1,
        REG_GAIN_P      = 3'd2,
        REG_GAIN_I      = 3'd3,
        REG_GAIN_D      = 3'd4,
        REG_POWER_LIMIT = 3'd5,
        REG_ERROR_GATE  = 3'd6
    } cfg_idx_t;

    // Input item kinds
    typedef enum logic {
        KIND_START  = 1'b0,
        KIND_SAMPLE = 1'b1
    } kind_t;

endpackage

### src/vision_centering_pid.sv
// ----------------------------------------------------------------------------
// vision_centering_pid
// PID loop that centers the drive on a camera target, with output clamp,
// error gate and drive timeout.
// ----------------------------------------------------------------------------
//
//  Channel | Signals                                   | Direction | Handshake
//  --------+-------------------------------------------+-----------+------------
//  input   | in_valid, in_stall, kind, x_coord         | in        | valid/stall
//  output  | out_valid, out_stall, drive_power,        | out       | valid/stall
//          | error_too_large, timed_out                |           |
//  config  | cfg_valid, cfg_ready, cfg_index, cfg_data | in        | valid/ready
//
//  An accepted item is held in the input register, then goes through the PID
//  datapath into the result register. The datapath (three parallel multiplies,
//  their sum, truncation and clamp) sits between those two registers, so one
//  item is accepted every cycle while the output does not stall.
//  Reset clears the loop state and loads the register defaults.
//  A stall on the output holds the result register and, once the input
//  register is also full, raises in_stall in the same cycle.
//  Configuration is always ready.
//
module vision_centering_pid
(
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 kind,
    input  logic [vcp_pkg::COORD_W-1:0]          x_coord,

    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [vcp_pkg::POWER_W-1:0]   drive_power,
    output logic                                 error_too_large,
    output logic                                 timed_out,

    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [vcp_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [vcp_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import vcp_pkg::*;

    // Configuration registers
    logic [COORD_W-1:0] target_reg;
    logic [TIME_W-1:0]  timeout_reg;
    logic [GAIN_W-1:0]  gain_p_reg;
    logic [GAIN_W-1:0]  gain_i_reg;
    logic [GAIN_W-1:0]  gain_d_reg;
    logic [LIMIT_W-1:0] limit_reg;
    logic [COORD_W-1:0] gate_reg;

    // Loop state
    logic signed [ERR_W-1:0]    prev_err_reg;
    logic signed [ERR_W-1:0]    prev_err_next;
    logic signed [SUM_BITS-1:0] sum_reg;
    logic signed [SUM_BITS-1:0] sum_next;
    logic [ELAPSED_W-1:0]       elapsed_reg;
    logic [ELAPSED_W-1:0]       elapsed_next;

    // Input register
    logic               in_vld_reg;
    logic               in_kind_reg;
    logic [COORD_W-1:0] in_x_reg;

    // Result register
    logic                       out_vld_reg;
    logic signed [POWER_W-1:0]  power_reg;
    logic signed [POWER_W-1:0]  power_next;
    logic                       gated_reg;
    logic                       gated_next;
    logic                       tout_reg;
    logic                       tout_next;

    // Datapath
    logic                        advance;
    logic                        load_in;
    logic                        fire;
    logic signed [ERR_W-1:0]     err;
    logic [ERR_W-1:0]            err_mag;
    logic signed [SUM_BITS:0]    sum_wide;
    logic signed [SUM_BITS-1:0]  sum_sat;
    logic signed [DERR_W-1:0]    derr;
    logic signed [PROD_P_W-1:0]  prod_p;
    logic signed [PROD_I_W-1:0]  prod_i;
    logic signed [PROD_D_W-1:0]  prod_d;
    logic signed [TOTAL_W-1:0]   total;
    logic signed [TOTAL_W-1:0]   total_adj;
    logic signed [TOTAL_W-1:0]   power_wide;
    logic signed [TOTAL_W-1:0]   lim_pos;
    logic signed [TOTAL_W-1:0]   lim_neg;
    logic signed [TOTAL_W-1:0]   power_clamp;
    logic                        gated;
    logic                        expired;
    logic [ELAPSED_W:0]          elapsed_sum;

    // ------------------------------------------------------------------
    // Flow control: the result register empties or is taken this cycle,
    // then the input register moves forward and can take a new item.
    // ------------------------------------------------------------------
    assign advance  = !out_vld_reg || !out_stall;
    assign in_stall = in_vld_reg && !advance;
    assign load_in  = in_valid && !in_stall;
    assign fire     = in_vld_reg && advance;

    assign cfg_ready = 1'b1;

    // ------------------------------------------------------------------
    // PID datapath for the item in the input register
    // ------------------------------------------------------------------
    assign err = $signed({1'b0, target_reg}) - $signed({1'b0, in_x_reg});
    assign err_mag = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);

    // Saturating accumulate: overflow shows as differing top two bits
    assign sum_wide = {sum_reg[SUM_BITS-1], sum_reg}
                    + (SUM_BITS+1)'(err);
    always_comb
    begin
        if (sum_wide[SUM_BITS] != sum_wide[SUM_BITS-1])
        begin
            sum_sat = sum_wide[SUM_BITS] ? {1'b1, {(SUM_BITS-1){1'b0}}}
                                         : {1'b0, {(SUM_BITS-1){1'b1}}};
        end
        else
        begin
            sum_sat = sum_wide[SUM_BITS-1:0];
        end
    end

    // Derivative uses the error from before this sample
    assign derr = DERR_W'(err) - DERR_W'(prev_err_reg);

    assign prod_p = $signed({1'b0, gain_p_reg}) * err;
    assign prod_i = $signed({1'b0, gain_i_reg}) * sum_sat;
    assign prod_d = $signed({1'b0, gain_d_reg}) * derr;

    assign total = TOTAL_W'(prod_p) + TOTAL_W'(prod_i) + TOTAL_W'(prod_d);

    // Truncate toward zero: bias negative values before the arithmetic shift
    assign total_adj  = total + (total[TOTAL_W-1]
                      ? TOTAL_W'((1 << GAIN_FRAC_BITS) - 1) : TOTAL_W'(0));
    assign power_wide = total_adj >>> GAIN_FRAC_BITS;

    assign lim_pos = $signed(TOTAL_W'(limit_reg));
    assign lim_neg = -lim_pos;

    always_comb
    begin
        if (power_wide > lim_pos)
        begin
            power_clamp = lim_pos;
        end
        else if (power_wide < lim_neg)
        begin
            power_clamp = lim_neg;
        end
        else
        begin
            power_clamp = power_wide;
        end
    end

    assign gated   = err_mag > {1'b0, gate_reg};
    assign expired = elapsed_reg >= ELAPSED_W'(timeout_reg);

    assign elapsed_sum = {1'b0, elapsed_reg} + (ELAPSED_W+1)'(TICK_MS);

    // ------------------------------------------------------------------
    // Result and next state per item kind
    // ------------------------------------------------------------------
    always_comb
    begin
        prev_err_next = prev_err_reg;
        sum_next      = sum_reg;
        elapsed_next  = elapsed_reg;
        power_next    = '0;
        gated_next    = 1'b0;
        tout_next     = 1'b0;

        if (in_kind_reg == KIND_START)
        begin
            // Clear the loop state, report zero power
            prev_err_next = '0;
            sum_next      = '0;
            elapsed_next  = '0;
        end
        else if (expired)
        begin
            // Drive window over: hold state, flag timeout
            tout_next = 1'b1;
        end
        else
        begin
            prev_err_next = err;
            sum_next      = sum_sat;
            elapsed_next  = elapsed_sum[ELAPSED_W] ? ELAPSED_MAX
                                                   : elapsed_sum[ELAPSED_W-1:0];
            gated_next    = gated;
            power_next    = gated ? '0 : power_clamp[POWER_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg  <= TARGET_RST;
            timeout_reg <= TIMEOUT_RST;
            gain_p_reg  <= GAIN_P_RST;
            gain_i_reg  <= GAIN_I_RST;
            gain_d_reg  <= GAIN_D_RST;
            limit_reg   <= LIMIT_RST;
            gate_reg    <= GATE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_idx_t'(cfg_index))
                REG_TARGET_X:    target_reg  <= cfg_data[COORD_W-1:0];
                REG_TIMEOUT_MS:  timeout_reg <= cfg_data[TIME_W-1:0];
                REG_GAIN_P:      gain_p_reg  <= cfg_data[GAIN_W-1:0];
                REG_GAIN_I:      gain_i_reg  <= cfg_data[GAIN_W-1:0];
                REG_GAIN_D:      gain_d_reg  <= cfg_data[GAIN_W-1:0];
                REG_POWER_LIMIT: limit_reg   <= cfg_data[LIMIT_W-1:0];
                REG_ERROR_GATE:  gate_reg    <= cfg_data[COORD_W-1:0];
                default:         ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Control and loop state
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg   <= 1'b0;
            out_vld_reg  <= 1'b0;
            prev_err_reg <= '0;
            sum_reg      <= '0;
            elapsed_reg  <= '0;
        end
        else
        begin
            if (!in_stall)
            begin
                in_vld_reg <= in_valid;
            end
            if (advance)
            begin
                out_vld_reg <= in_vld_reg;
            end
            if (fire)
            begin
                prev_err_reg <= prev_err_next;
                sum_reg      <= sum_next;
                elapsed_reg  <= elapsed_next;
            end
        end
    end

    // Payload registers: load on handshake, hold while stalled
    always_ff @(posedge clk)
    begin
        if (load_in)
        begin
            in_kind_reg <= kind;
            in_x_reg    <= x_coord;
        end
        if (fire)
        begin
            power_reg <= power_next;
            gated_reg <= gated_next;
            tout_reg  <= tout_next;
        end
    end

    assign out_valid       = out_vld_reg;
    assign drive_power     = power_reg;
    assign error_too_large = gated_reg;
    assign timed_out       = tout_reg;

endmodule

### test/vision_centering_pid_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vision_centering_pid_tb
// Self-checking testbench of the vision centering PID loop. A scoreboard
// class tracks the loop state and register settings, predicts every drive
// result from the accepted items and checks the results in order. Directed
// items cover the gate, clamp, timeout and truncation corners. Random phases
// then reconfigure the loop and drive start/sample runs, while both channels
// idle at random.
// ----------------------------------------------------------------------------
module vision_centering_pid_tb;
    import vcp_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned RANDOM_ITEMS = 1350;
    localparam int unsigned PHASE_ITEMS  = 110;
    localparam int unsigned IDLE_PCT     = 32;
    localparam int unsigned HOLD_CYCLES  = 64;
    localparam int unsigned SETTLE       = 4;
    // Index past the last register: the block must ignore writes to it
    localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;

    typedef struct packed {
        logic signed [POWER_W-1:0] power;
        logic                      too_large;
        logic                      timed_out;
    } drive_t;

    // ------------------------------------------------------------------------
    // Scoreboard: own copy of the registers and loop state, expected drive
    // results queued in acceptance order.
    // ------------------------------------------------------------------------
    class drive_scoreboard;
        logic [COORD_W-1:0]        target_x;
        logic [TIME_W-1:0]         timeout_ms;
        logic [GAIN_W-1:0]         gain_p;
        logic [GAIN_W-1:0]         gain_i;
        logic [GAIN_W-1:0]         gain_d;
        logic [LIMIT_W-1:0]        power_limit;
        logic [COORD_W-1:0]        error_gate;
        logic signed [ERR_W-1:0]   last_err;
        logic signed [SUM_BITS-1:0] err_sum;
        logic [ELAPSED_W-1:0]      elapsed;
        drive_t                    pending[$];
        int unsigned               errors;

        function new();
            target_x    = TARGET_RST;
            timeout_ms  = TIMEOUT_RST;
            gain_p      = GAIN_P_RST;
            gain_i      = GAIN_I_RST;
            gain_d      = GAIN_D_RST;
            power_limit = LIMIT_RST;
            error_gate  = GATE_RST;
            last_err    = '0;
            err_sum     = '0;
            elapsed     = '0;
            errors      = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_TARGET_X:    target_x    = data[COORD_W-1:0];
                REG_TIMEOUT_MS:  timeout_ms  = data[TIME_W-1:0];
                REG_GAIN_P:      gain_p      = data[GAIN_W-1:0];
                REG_GAIN_I:      gain_i      = data[GAIN_W-1:0];
                REG_GAIN_D:      gain_d      = data[GAIN_W-1:0];
                REG_POWER_LIMIT: power_limit = data[LIMIT_W-1:0];
                REG_ERROR_GATE:  error_gate  = data[COORD_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_item(kind_t k, logic [COORD_W-1:0] x);
            drive_t r;
            longint err;
            longint sum;
            longint smax;
            longint total;
            longint pwr;
            longint lim;
            longint mag;
            r = '0;
            if (k == KIND_START)
            begin
                last_err = '0;
                err_sum  = '0;
                elapsed  = '0;
            end
            else if (elapsed >= timeout_ms)
                r.timed_out = 1'b1;
            else
            begin
                err  = longint'(target_x) - longint'(x);
                smax = (longint'(1) << (SUM_BITS - 1)) - 1;
                sum  = longint'(err_sum) + err;
                if (sum > smax)
                    sum = smax;
                if (sum < -smax - 1)
                    sum = -smax - 1;
                total = longint'(gain_p) * err + longint'(gain_i) * sum
                      + longint'(gain_d) * (err - longint'(last_err));
                // signed division truncates toward zero
                pwr = total / (longint'(1) << GAIN_FRAC_BITS);
                lim = longint'(power_limit);
                if (pwr > lim)
                    pwr = lim;
                if (pwr < -lim)
                    pwr = -lim;
                mag = (err < 0) ? -err : err;
                if (mag > longint'(error_gate))
                begin
                    pwr         = 0;
                    r.too_large = 1'b1;
                end
                r.power  = pwr[POWER_W-1:0];
                err_sum  = sum[SUM_BITS-1:0];
                last_err = err[ERR_W-1:0];
                if (elapsed > ELAPSED_MAX - ELAPSED_W'(TICK_MS))
                    elapsed = ELAPSED_MAX;
                else
                    elapsed = elapsed + ELAPSED_W'(TICK_MS);
            end
            pending.push_back(r);
        endfunction

        function void check_result(logic signed [POWER_W-1:0] power, logic too_large,
                                   logic timed_out);
            drive_t want;
            if (pending.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, power %0d too_large %0b timed_out %0b",
                         $time, power, too_large, timed_out);
                return;
            end
            want = pending.pop_front();
            if (power !== want.power)
            begin
                errors++;
                $display("%0t: drive_power expected %0d actual %0d",
                         $time, $signed(want.power), power);
            end
            if (too_large !== want.too_large)
            begin
                errors++;
                $display("%0t: error_too_large expected %0b actual %0b",
                         $time, want.too_large, too_large);
            end
            if (timed_out !== want.timed_out)
            begin
                errors++;
                $display("%0t: timed_out expected %0b actual %0b",
                         $time, want.timed_out, timed_out);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Block signals; every input starts at a known value
    // ------------------------------------------------------------------------
    logic                      clk;
    logic                      rst_n     = 1'b0;
    logic                      in_valid  = 1'b0;
    logic                      in_stall;
    kind_t                     item_kind = KIND_START;
    logic [COORD_W-1:0]        x_coord   = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic signed [POWER_W-1:0] drive_power;
    logic                      error_too_large;
    logic                      timed_out;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_IDX_W-1:0]      cfg_index = '0;
    logic [CFG_DATA_W-1:0]     cfg_data  = '0;

    drive_scoreboard sb;
    int unsigned     items_sent  = 0;
    int unsigned     cycle_count = 0;
    int unsigned     hold_at     = 0;
    bit              calm        = 1'b0;   // no idling on either side
    bit              hold_req    = 1'b0;   // ask the receiver for a long hold-off

    vision_centering_pid i_dut
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .kind            (item_kind),
        .x_coord         (x_coord),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .drive_power     (drive_power),
        .error_too_large (error_too_large),
        .timed_out       (timed_out),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #5 clk = ~clk;
    end

    // Watchdog: end the run if the block hangs
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Check every result the moment it leaves the block
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(drive_power, error_too_large, timed_out);
    end

    // Receiver: random stalls, except in calm stretches; on request hold off
    // for a long stretch so the block fills up and stalls its input.
    initial
    begin
        int unsigned hold_left;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // ------------------------------------------------------------------------
    // Drivers. Every task starts and ends on a falling edge. Valid stays up
    // between back-to-back items, so it gets one assignment per step.
    // ------------------------------------------------------------------------

    // Offer one item, idling at random first; hold it until accepted.
    task automatic send_item(kind_t k, logic [COORD_W-1:0] x);
        while (!calm && ($urandom_range(0, 99) < IDLE_PCT))
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        item_kind <= k;
        x_coord   <= x;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_item(k, x);
        items_sent++;
        if (items_sent == hold_at)
            hold_req = 1'b1;
        @(negedge clk);
    endtask

    // Write one register; cfg_valid is left up for the caller to drop.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.set_reg(idx, data);
        @(negedge clk);
    endtask

    // Drop valid and wait until every expected result has come back.
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (SETTLE)
            @(negedge clk);
    endtask

    // Write the whole register set, sometimes with a stray write past the end.
    task automatic configure(logic [CFG_DATA_W-1:0] tx, logic [CFG_DATA_W-1:0] tmo,
                             logic [CFG_DATA_W-1:0] gp, logic [CFG_DATA_W-1:0] gi,
                             logic [CFG_DATA_W-1:0] gd, logic [CFG_DATA_W-1:0] lim,
                             logic [CFG_DATA_W-1:0] gate);
        write_reg(REG_TARGET_X, tx);
        write_reg(REG_TIMEOUT_MS, tmo);
        write_reg(REG_GAIN_P, gp);
        write_reg(REG_GAIN_I, gi);
        write_reg(REG_GAIN_D, gd);
        write_reg(REG_POWER_LIMIT, lim);
        write_reg(REG_ERROR_GATE, gate);
        if ($urandom_range(0, 3) == 0)
            write_reg(REG_NONE, CFG_DATA_W'($urandom_range(0, 65535)));
        cfg_valid <= 1'b0;
    endtask

    // Register value: extremes, a typical range or anything, with random
    // junk above the field width that the block must mask off.
    function automatic logic [CFG_DATA_W-1:0] cfg_value(int unsigned mask,
                                                        int unsigned typical);
        int unsigned v;
        case ($urandom_range(0, 9))
            0:          v = 0;
            1:          v = mask;
            2, 3, 4, 5: v = $urandom_range(0, typical);
            default:    v = $urandom_range(0, mask);
        endcase
        return CFG_DATA_W'(v | ($urandom_range(0, 65535) & ~mask));
    endfunction

    // Camera sample: half near the target so the loop stays ungated, half anywhere.
    function automatic logic [COORD_W-1:0] sample_x(logic [COORD_W-1:0] aim);
        int v;
        if ($urandom_range(0, 1) == 1)
            return COORD_W'($urandom_range(0, 1023));
        v = int'(aim) + int'($urandom_range(0, 120)) - 60;
        if (v < 0)
            v = 0;
        if (v > 1023)
            v = 1023;
        return COORD_W'(v);
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        int unsigned phase;
        int unsigned phase_items;
        int unsigned run_len;
        int unsigned stop_at;
        int unsigned sel;

        sb = new();
        repeat (3)
            @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset defaults: timeout 0, so any sample times out at once
        send_item(KIND_START, COORD_W'($urandom_range(0, 1023)));
        send_item(KIND_SAMPLE, '0);
        drain();

        // Target 512 (junk in the upper bits), a 100 ms window = 5 samples.
        // Walk through gated errors both ways, a derivative kick into the
        // clamp, error right at the gate, just inside it, then time out.
        write_reg(REG_TARGET_X, 16'hFE00);
        write_reg(REG_TIMEOUT_MS, 16'd100);
        write_reg(REG_NONE, 16'hFFFF);
        cfg_valid <= 1'b0;
        send_item(KIND_START, 10'h3FF);
        send_item(KIND_SAMPLE, 10'h3FF);
        send_item(KIND_SAMPLE, 10'd0);
        send_item(KIND_SAMPLE, 10'd512);
        send_item(KIND_SAMPLE, 10'd312);
        send_item(KIND_SAMPLE, 10'd711);
        send_item(KIND_SAMPLE, 10'd700);
        drain();

        // Full gains and limit, widest gate: clamp hard negative...
        configure(16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd127, 16'd1023);
        send_item(KIND_START, '0);
        send_item(KIND_SAMPLE, 10'd0);
        send_item(KIND_SAMPLE, 10'h3FF);
        send_item(KIND_SAMPLE, 10'd1);
        drain();

        // ...and hard positive
        configure(16'd1023, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd127, 16'd1023);
        send_item(KIND_START, '0);
        send_item(KIND_SAMPLE, 10'd0);
        send_item(KIND_SAMPLE, 10'h3FF);
        drain();

        // Just over unity gain: +/-1 error must truncate toward zero
        configure(16'd512, 16'hFFFF, 16'd4097, 16'd0, 16'd0, 16'd127, 16'd1023);
        send_item(KIND_START, '0);
        send_item(KIND_SAMPLE, 10'd513);
        send_item(KIND_SAMPLE, 10'd511);
        drain();

        // Zero limit and zero gate: zero error passes, any error is gated
        configure(16'd512, 16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        send_item(KIND_START, '0);
        send_item(KIND_SAMPLE, 10'd512);
        send_item(KIND_SAMPLE, 10'd513);
        drain();

        // Random phases: new settings each phase, then mostly start-led runs
        // of samples, with stray samples and lone starts mixed in.
        stop_at = items_sent + RANDOM_ITEMS;
        phase   = 0;
        while (items_sent < stop_at)
        begin
            calm = (phase == 3);
            if (phase == 2)
                hold_at = items_sent + 40;
            configure(cfg_value(10'h3FF, 1023), cfg_value(16'hFFFF, 3000),
                      cfg_value(16'hFFFF, 8192), cfg_value(16'hFFFF, 512),
                      cfg_value(16'hFFFF, 8192), cfg_value(7'h7F, 127),
                      cfg_value(10'h3FF, 300));
            phase_items = 0;
            while (phase_items < PHASE_ITEMS)
            begin
                sel = $urandom_range(0, 19);
                if (sel == 0)
                begin
                    send_item(KIND_SAMPLE, COORD_W'($urandom_range(0, 1023)));
                    phase_items++;
                end
                else if (sel == 1)
                begin
                    send_item(KIND_START, COORD_W'($urandom_range(0, 1023)));
                    phase_items++;
                end
                else
                begin
                    send_item(KIND_START, COORD_W'($urandom_range(0, 1023)));
                    run_len = $urandom_range(1, 40);
                    repeat (run_len)
                        send_item(KIND_SAMPLE, sample_x(sb.target_x));
                    phase_items += run_len + 1;
                end
            end
            drain();
            calm = 1'b0;
            phase++;
        end

        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
